// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl, compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RAU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rau assertion failed");
`define RAU_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rau forbidden condition seen");
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop)
`define RAU_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/core/rau_pkg.sv -----
package rau_pkg;

    localparam int WIDE     = 64;
    localparam int NUM_BITS = 32;
    localparam int DEN_BITS = 31;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_INC  = 3'd2;
    localparam logic [2:0] OP_LT   = 3'd3;
    localparam logic [2:0] OP_EQ   = 3'd4;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD_IN,
        CMD_SET_ONE,
        CMD_GCD_START,
        CMD_DIV_N_START,
        CMD_WR_N,
        CMD_WR_D,
        CMD_SAVE_OPND,
        CMD_MUL_A,
        CMD_MUL_B,
        CMD_MUL_C,
        CMD_WR_PROD_D,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic       gcd_done;
        logic       div_done;
        logic       n_zero;
        logic       d_zero;
        logic [2:0] op;
        logic       out_free;
    } t_status;

endpackage

// ----- rtl/core/rational_accumulator_unit_top.sv -----
// Rational accumulator: keeps one signed fraction in lowest terms and applies one operation
// (load, add, increment, less-than, equal) per input transfer, giving one result transfer each.
// Items are worked one at a time. Every item, whatever its code, first normalises its operand;
// an operand of 0/0 skips that. Load, equal, increment and the unused codes then finish,
// less-than adds two multiply steps, and add does a second normalisation of the sum after
// the multiply steps and a write of the product denominator. Each normalisation costs a
// bit-serial binary gcd (one shift or subtract per cycle on 64-bit magnitudes) and two
// restoring divisions. A finished result waits in the output register while the next item
// is already taken in.
module rational_accumulator_unit_top #(
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_op,
    input  logic signed [31:0]            i_operand_num,
    input  logic signed [31:0]            i_operand_den,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_result_num,
    output logic [rau_pkg::DEN_BITS-1:0]  o_result_den,
    output logic                          o_compare_true,
    output logic                          o_nonzero,
    output logic                          o_overflow
);
    import rau_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rau_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_op           (i_op),
        .i_operand_num  (i_operand_num),
        .i_operand_den  (i_operand_den),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_result_num   (o_result_num),
        .o_result_den   (o_result_den),
        .o_compare_true (o_compare_true),
        .o_nonzero      (o_nonzero),
        .o_overflow     (o_overflow)
    );

endmodule

// ----- rtl/core/rau_gcd.sv -----
module rau_gcd (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rau_pkg::WIDE-1:0]  i_a,
    input  logic [rau_pkg::WIDE-1:0]  i_b,
    output logic                      o_done,
    output logic [rau_pkg::WIDE-1:0]  o_g
);
    import rau_pkg::*;

    localparam int KW = $clog2(WIDE);

    logic            r_busy;
    logic            r_done;
    logic [WIDE-1:0] r_a;
    logic [WIDE-1:0] r_b;
    logic [WIDE-1:0] r_g;
    logic [KW-1:0]   r_k;
    logic [WIDE-1:0] w_amb;
    logic [WIDE-1:0] w_bma;

    assign w_amb = r_a - r_b;
    assign w_bma = r_b - r_a;

    // binary gcd: one shift or subtract-and-shift per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_b    <= i_b;
                r_k    <= '0;
            end else if (r_busy) begin
                priority if (r_a == '0 || r_b == '0) begin
                    r_g    <= (r_a | r_b) << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= w_amb >> 1;
                end else begin
                    r_b <= w_bma >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

// ----- rtl/core/rau_div.sv -----
module rau_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rau_pkg::WIDE-1:0]  i_dividend,
    input  logic [rau_pkg::WIDE-1:0]  i_divisor,
    output logic                      o_done,
    output logic [rau_pkg::WIDE-1:0]  o_quot
);
    import rau_pkg::*;

    localparam int KW = $clog2(WIDE);

    logic            r_busy;
    logic            r_done;
    logic [KW-1:0]   r_cnt;
    logic [WIDE-1:0] r_q;
    logic [WIDE-1:0] r_r;
    logic [WIDE-1:0] r_dv;
    logic [WIDE:0]   w_sh;
    logic [WIDE:0]   w_sub;
    logic            w_ge;

    assign w_sh  = {r_r, r_q[WIDE-1]};
    assign w_ge  = w_sh >= {1'b0, r_dv};
    assign w_sub = w_sh - {1'b0, r_dv};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_dv   <= i_divisor;
            end else if (r_busy) begin
                r_r   <= w_ge ? w_sub[WIDE-1:0] : w_sh[WIDE-1:0];
                r_q   <= {r_q[WIDE-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/core/rau_datapath.sv -----
`include "assert_macros.svh"

module rau_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rau_pkg::t_cmd                 i_cmd,
    output rau_pkg::t_status              o_status,
    input  logic [2:0]                    i_op,
    input  logic signed [31:0]            i_operand_num,
    input  logic signed [31:0]            i_operand_den,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [31:0]            o_result_num,
    output logic [rau_pkg::DEN_BITS-1:0]  o_result_den,
    output logic                          o_compare_true,
    output logic                          o_nonzero,
    output logic                          o_overflow
);
    import rau_pkg::*;

    localparam logic signed [WIDE-1:0] LIM = 64'sd1 <<< (WORD_BITS - 1);

    logic [2:0]                  r_op;
    logic signed [WIDE-1:0]      r_n;
    logic signed [WIDE-1:0]      r_d;
    logic                        r_neg;
    logic signed [32:0]          r_rn;
    logic [31:0]                 r_rd;
    logic signed [WIDE-1:0]      r_prod;
    logic signed [NUM_BITS-1:0]  r_acc_num;
    logic [DEN_BITS-1:0]         r_acc_den;
    logic                        r_out_valid;
    logic signed [NUM_BITS-1:0]  r_res_num;
    logic [DEN_BITS-1:0]         r_res_den;
    logic                        r_res_cmp;
    logic                        r_res_nz;
    logic                        r_res_ovf;

    logic signed [NUM_BITS-1:0]  n_acc_num;
    logic [DEN_BITS-1:0]         n_acc_den;
    logic                        n_cmp;
    logic                        n_ovf;

    logic signed [32:0]          w_ma;
    logic signed [32:0]          w_mb;
    logic signed [65:0]          w_mul;
    logic [WIDE-1:0]             w_mag_n;
    logic [WIDE-1:0]             w_mag_d;
    logic                        w_gcd_done;
    logic [WIDE-1:0]             w_g;
    logic                        w_div_start;
    logic [WIDE-1:0]             w_dividend;
    logic                        w_div_done;
    logic [WIDE-1:0]             w_q;
    logic signed [WIDE-1:0]      w_rn64;
    logic signed [WIDE-1:0]      w_rd64;
    logic signed [WIDE-1:0]      w_an64;
    logic signed [WIDE-1:0]      w_ad64;
    logic signed [WIDE-1:0]      w_inc;

    function automatic logic fits_num(input logic signed [WIDE-1:0] v);
        return (v >= -LIM) && (v <= LIM - 64'sd1);
    endfunction

    function automatic logic fits_den(input logic signed [WIDE-1:0] v);
        return (v >= 64'sd0) && (v <= LIM - 64'sd1);
    endfunction

    assign w_mag_n = r_n[WIDE-1] ? WIDE'(-r_n) : WIDE'(r_n);
    assign w_mag_d = r_d[WIDE-1] ? WIDE'(-r_d) : WIDE'(r_d);

    // one shared multiplier, operands picked by the current step
    always_comb begin
        unique case (i_cmd)
            CMD_MUL_A: begin
                w_ma = r_rn;
                w_mb = $signed({2'b00, r_acc_den});
            end
            CMD_MUL_B: begin
                w_ma = $signed({r_acc_num[NUM_BITS-1], r_acc_num});
                w_mb = $signed({1'b0, r_rd});
            end
            default: begin
                w_ma = $signed({1'b0, r_rd});
                w_mb = $signed({2'b00, r_acc_den});
            end
        endcase
    end

    assign w_mul = w_ma * w_mb;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd == CMD_GCD_START),
        .i_a     (w_mag_n),
        .i_b     (w_mag_d),
        .o_done  (w_gcd_done),
        .o_g     (w_g)
    );

    assign w_div_start = (i_cmd == CMD_DIV_N_START) || (i_cmd == CMD_WR_N);
    assign w_dividend  = (i_cmd == CMD_WR_N) ? w_mag_d : w_mag_n;

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_g),
        .o_done     (w_div_done),
        .o_quot     (w_q)
    );

    assign w_rn64 = WIDE'(r_rn);
    assign w_rd64 = $signed({32'b0, r_rd});
    assign w_an64 = WIDE'(r_acc_num);
    assign w_ad64 = $signed({{(WIDE-DEN_BITS){1'b0}}, r_acc_den});
    assign w_inc  = w_an64 + w_ad64;

    // new accumulator and flags at the end of an item
    always_comb begin
        n_acc_num = r_acc_num;
        n_acc_den = r_acc_den;
        n_cmp     = 1'b0;
        n_ovf     = 1'b0;
        unique case (r_op)
            OP_LOAD: begin
                if (fits_num(w_rn64) && fits_den(w_rd64)) begin
                    n_acc_num = r_rn[NUM_BITS-1:0];
                    n_acc_den = r_rd[DEN_BITS-1:0];
                end else begin
                    n_ovf = 1'b1;
                end
            end
            OP_ADD: begin
                if (fits_num(r_n) && fits_den(r_d)) begin
                    n_acc_num = r_n[NUM_BITS-1:0];
                    n_acc_den = r_d[DEN_BITS-1:0];
                end else begin
                    n_ovf = 1'b1;
                end
            end
            OP_INC: begin
                if (fits_num(w_inc)) begin
                    n_acc_num = w_inc[NUM_BITS-1:0];
                end else begin
                    n_ovf = 1'b1;
                end
            end
            // r_prod holds acc_num*den, r_n holds num*acc_den
            OP_LT: n_cmp = r_prod < r_n;
            OP_EQ: n_cmp = (w_rn64 == w_an64) && (w_rd64 == w_ad64);
            default: n_cmp = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc_num   <= '0;
            r_acc_den   <= DEN_BITS'(1);
        end else begin
            // a finish in the same cycle refills the register instead
            if (r_out_valid && !i_out_stall && i_cmd != CMD_FINISH) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd)
                CMD_LOAD_IN: begin
                    r_op <= i_op;
                    r_n  <= WIDE'(i_operand_num);
                    r_d  <= WIDE'(i_operand_den);
                end
                CMD_SET_ONE:   r_n   <= 64'sd1;
                CMD_GCD_START: r_neg <= r_n[WIDE-1] ^ r_d[WIDE-1];
                CMD_WR_N:      r_n   <= r_neg ? -$signed(w_q) : $signed(w_q);
                CMD_WR_D:      r_d   <= $signed(w_q);
                CMD_SAVE_OPND: begin
                    r_rn <= r_n[32:0];
                    r_rd <= r_d[31:0];
                end
                CMD_MUL_A: r_prod <= w_mul[WIDE-1:0];
                CMD_MUL_B: begin
                    r_n    <= r_prod;
                    r_prod <= w_mul[WIDE-1:0];
                end
                CMD_MUL_C: begin
                    r_n    <= r_n + r_prod;
                    r_prod <= w_mul[WIDE-1:0];
                end
                CMD_WR_PROD_D: r_d <= r_prod;
                CMD_FINISH: begin
                    r_acc_num   <= n_acc_num;
                    r_acc_den   <= n_acc_den;
                    r_res_num   <= n_acc_num;
                    r_res_den   <= n_acc_den;
                    r_res_cmp   <= n_cmp;
                    r_res_nz    <= n_acc_num != '0;
                    r_res_ovf   <= n_ovf;
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status.gcd_done = w_gcd_done;
        o_status.div_done = w_div_done;
        o_status.n_zero   = r_n == '0;
        o_status.d_zero   = r_d == '0;
        o_status.op       = r_op;
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_num   = r_res_num;
    assign o_result_den   = r_res_den;
    assign o_compare_true = r_res_cmp;
    assign o_nonzero      = r_res_nz;
    assign o_overflow     = r_res_ovf;

    `RAU_ASSERT(a_fin_free, i_clk, i_rst_n, (i_cmd == CMD_FINISH) |-> (!r_out_valid || !i_out_stall))
    `RAU_ASSERT(a_fin_valid, i_clk, i_rst_n, (i_cmd == CMD_FINISH) |=> r_out_valid)
    `RAU_ASSERT(a_ovf_keeps, i_clk, i_rst_n, (i_cmd == CMD_FINISH && n_ovf) |=> ($stable(r_acc_num) && $stable(r_acc_den)))
    `RAU_ASSERT(a_cmp_op, i_clk, i_rst_n, (i_cmd == CMD_FINISH && r_op != OP_LT && r_op != OP_EQ) |=> !r_res_cmp)
    `RAU_NEVER(a_units_overlap, i_clk, i_rst_n, w_gcd_done && w_div_done)

endmodule

// ----- rtl/core/rau_ctrl.sv -----
module rau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rau_pkg::t_status  i_status,
    output rau_pkg::t_cmd     o_cmd
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_GCD, S_DIVN, S_DIVD, S_OPND,
        S_M1, S_M2, S_M3, S_M4, S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state w_after;
    logic   r_second;
    logic   n_second;

    // second normalisation (of the sum) goes straight to the finish
    assign w_after = r_second ? S_FIN : S_OPND;

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_cmd    = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd    = CMD_LOAD_IN;
                    n_state  = S_CHK;
                    n_second = 1'b0;
                end
            end
            S_CHK: begin
                priority if (i_status.n_zero && i_status.d_zero) begin
                    n_state = w_after;
                end else if (i_status.d_zero) begin
                    o_cmd   = CMD_SET_ONE;
                    n_state = w_after;
                end else begin
                    o_cmd   = CMD_GCD_START;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd   = CMD_DIV_N_START;
                    n_state = S_DIVN;
                end
            end
            S_DIVN: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_WR_N;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_WR_D;
                    n_state = w_after;
                end
            end
            S_OPND: begin
                o_cmd   = CMD_SAVE_OPND;
                n_state = (i_status.op == OP_ADD || i_status.op == OP_LT) ? S_M1 : S_FIN;
            end
            S_M1: begin
                o_cmd   = CMD_MUL_A;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd   = CMD_MUL_B;
                n_state = (i_status.op == OP_LT) ? S_FIN : S_M3;
            end
            S_M3: begin
                o_cmd   = CMD_MUL_C;
                n_state = S_M4;
            end
            S_M4: begin
                o_cmd    = CMD_WR_PROD_D;
                n_second = 1'b1;
                n_state  = S_CHK;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

// ----- dv/tb_rational_accumulator_unit_top.sv -----
module tb_rational_accumulator_unit_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam int          ACC_BITS     = 32;
    localparam logic [2:0]  OP_NOP_FIRST = 3'd5;
    localparam logic [2:0]  OP_NOP_MID   = 3'd6;
    localparam logic [2:0]  OP_NOP_LAST  = 3'd7;
    localparam longint      CYCLE_LIMIT  = 8_000_000;
    localparam int          DRAIN_CYCLES = 700;

    typedef struct {
        logic signed [31:0]   num;
        logic [DEN_BITS-1:0]  den;
        logic                 cmp;
        logic                 nz;
        logic                 ovf;
    } t_frac_result;

    class rat_scoreboard;
        longint       acc_num;
        longint       acc_den;
        t_frac_result pending_q[$];
        int           errors;

        function new();
            acc_num = 0;
            acc_den = 1;
            errors  = 0;
        endfunction

        // lowest terms, sign moved to the numerator
        function void reduce(inout longint n, inout longint d);
            longint unsigned an, ad, a, b, t, q;
            bit neg;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            if (an == 0 && ad == 0) return;
            if (ad == 0) begin
                n = 1;
                return;
            end
            a = an;
            b = ad;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            q   = an / a;
            neg = (n < 0) != (d < 0);
            n   = neg ? -longint'(q) : longint'(q);
            d   = longint'(ad / a);
        endfunction

        function bit num_fits(longint n);
            longint lim;
            lim = longint'(1) << (ACC_BITS - 1);
            return n >= -lim && n <= lim - 1;
        endfunction

        function bit den_fits(longint d);
            longint lim;
            lim = longint'(1) << (ACC_BITS - 1);
            return d >= 0 && d <= lim - 1;
        endfunction

        function void note_input(logic [2:0] op, logic signed [31:0] on,
                                 logic signed [31:0] od);
            longint rn, rd, nn, nd;
            t_frac_result r;
            bit cmp, ovf;
            rn  = on;
            rd  = od;
            cmp = 0;
            ovf = 0;
            reduce(rn, rd);
            case (op)
                OP_LOAD: begin
                    if (num_fits(rn) && den_fits(rd)) begin
                        acc_num = rn;
                        acc_den = rd;
                    end else ovf = 1;
                end
                OP_ADD: begin
                    nn = rn * acc_den + acc_num * rd;
                    nd = rd * acc_den;
                    reduce(nn, nd);
                    if (num_fits(nn) && den_fits(nd)) begin
                        acc_num = nn;
                        acc_den = nd;
                    end else ovf = 1;
                end
                OP_INC: begin
                    nn = acc_num + acc_den;
                    if (num_fits(nn)) acc_num = nn;
                    else ovf = 1;
                end
                OP_LT: cmp = (acc_num * rd) < (rn * acc_den);
                OP_EQ: cmp = (acc_num == rn) && (acc_den == rd);
                default: ;
            endcase
            r.num = acc_num[31:0];
            r.den = acc_den[DEN_BITS-1:0];
            r.cmp = cmp;
            r.nz  = acc_num != 0;
            r.ovf = ovf;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] num, logic [DEN_BITS-1:0] den,
                                   logic cmp, logic nz, logic ovf);
            t_frac_result e;
            if (pending_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (num !== e.num) begin
                $error("result_num expected %0d got %0d", e.num, num);
                errors++;
            end
            if (den !== e.den) begin
                $error("result_den expected %0d got %0d", e.den, den);
                errors++;
            end
            if (cmp !== e.cmp) begin
                $error("compare_true expected %0b got %0b", e.cmp, cmp);
                errors++;
            end
            if (nz !== e.nz) begin
                $error("nonzero expected %0b got %0b", e.nz, nz);
                errors++;
            end
            if (ovf !== e.ovf) begin
                $error("overflow expected %0b got %0b", e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [2:0]            i_op;
    logic signed [31:0]    i_operand_num;
    logic signed [31:0]    i_operand_den;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [31:0]    o_result_num;
    logic [DEN_BITS-1:0]   o_result_den;
    logic                  o_compare_true;
    logic                  o_nonzero;
    logic                  o_overflow;

    rat_scoreboard sb;
    int            gap_pct;
    int            stall_pct;
    longint        cycles;

    rational_accumulator_unit_top #(.WORD_BITS(ACC_BITS)) i_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_LOAD;
        i_operand_num = '0;
        i_operand_den = '0;
        i_out_stall   = 1'b0;
        gap_pct       = 0;
        stall_pct     = 0;
        cycles        = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rational_accumulator_unit_top verification failed");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_result_num, o_result_den, o_compare_true, o_nonzero,
                            o_overflow);

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(logic [2:0] op, logic signed [31:0] n, logic signed [31:0] d);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op          <= op;
        i_operand_num <= n;
        i_operand_den <= d;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(op, n, d);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2: return $urandom_range(40) - 20;
            3, 4:    return $urandom_range(2000) - 1000;
            5:       return $urandom;
            6:       return 32'sh8000_0000 + $urandom_range(3);
            7:       return 32'sh7fff_ffff - $urandom_range(3);
            default: return $urandom_range(200000) - 100000;
        endcase
    endfunction

    task automatic random_item();
        logic [2:0] op;
        logic signed [31:0] n, d;
        int k;
        case ($urandom_range(19))
            0, 1, 2, 3: op = OP_LOAD;
            4, 5, 6, 7, 8: op = OP_ADD;
            9, 10, 11: op = OP_INC;
            12, 13, 14: op = OP_LT;
            15, 16, 17: op = OP_EQ;
            18: op = 3'($urandom_range(OP_NOP_LAST, OP_NOP_FIRST));
            default: op = 3'($urandom);
        endcase
        n = pick_value();
        d = pick_value();
        // scaled copies of the accumulator so equality and ties actually happen
        if ((op == OP_EQ || op == OP_LT) && $urandom_range(1)) begin
            k = $urandom_range(1) ? 1 : -1;
            if ($urandom_range(3) == 0) k = k * 3;
            n = 32'(sb.acc_num * k);
            d = 32'(sb.acc_den * k);
        end
        send_item(op, n, d);
    endtask

    initial begin
        int phase;
        #1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(OP_EQ, 0, 1);
        send_item(OP_LOAD, 32'sh8000_0000, 1);
        send_item(OP_INC, 0, 0);
        send_item(OP_LOAD, 32'sh7fff_ffff, 1);
        send_item(OP_INC, 0, 0);
        send_item(OP_ADD, 1, 1);
        send_item(OP_LOAD, 0, 0);
        send_item(OP_ADD, 3, 4);
        send_item(OP_LOAD, 5, 0);
        send_item(OP_LT, -5, 0);
        send_item(OP_LOAD, 0, -7);
        send_item(OP_LOAD, -1, 32'sh8000_0000);
        send_item(OP_LOAD, 6, -4);
        send_item(OP_EQ, -3, 2);
        send_item(OP_LT, -1, 1);
        send_item(OP_LT, 32'sh8000_0000, 32'sh7fff_ffff);
        send_item(OP_ADD, 32'sh7fff_ffff, 32'sh7fff_fffe);
        send_item(OP_ADD, 32'sh8000_0000, 32'sh8000_0000);
        send_item(OP_NOP_FIRST, 9, 9);
        send_item(OP_NOP_MID, 32'shffff_ffff, 32'shffff_ffff);
        send_item(OP_NOP_LAST, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(OP_LOAD, 1, 3);
        send_item(OP_ADD, 1, -3);
        send_item(OP_INC, 0, 0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            repeat (190) random_item();
            hold_until_drained();
            repeat (192) random_item();
        end

        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("rational_accumulator_unit_top verification clean");
        else
            $display("rational_accumulator_unit_top verification failed");
        $finish;
    end
endmodule
